FILE: rtl/core/scp_pkg.sv
// ============================================================================
// scp_pkg
// shared types, character codes and status codes of the client-first parser
// ============================================================================
package scp_pkg;

    // default depth of the queue between classifier and parser
    localparam int SCP_FIFO_DEPTH = 4;

    // characters the parser looks for
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_CAP_C = 8'h43;
    localparam logic [7:0] CH_CAP_D = 8'h44;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_A     = 8'h61;

    // escape decoding phases
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_EQ    = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    // error flag bit positions, lowest bit has highest priority
    localparam int F_CBIND_P   = 0;
    localparam int F_BAD_GS2   = 1;
    localparam int F_AZ_ESC    = 2;
    localparam int F_BAD_AZ    = 3;
    localparam int F_MEXT      = 4;
    localparam int F_BAD_USR   = 5;
    localparam int F_USR_ESC   = 6;
    localparam int F_BAD_NONCE = 7;

    // status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NO_COMMA1   = 4'd1;
    localparam logic [3:0] ST_NO_COMMA2   = 4'd2;
    localparam logic [3:0] ST_NO_NONCE    = 4'd3;
    localparam logic [3:0] ST_CBIND_P     = 4'd4;
    localparam logic [3:0] ST_BAD_GS2     = 4'd5;
    localparam logic [3:0] ST_AZ_ESC      = 4'd6;
    localparam logic [3:0] ST_BAD_AZ      = 4'd7;
    localparam logic [3:0] ST_MEXT        = 4'd8;
    localparam logic [3:0] ST_BAD_USR     = 4'd9;
    localparam logic [3:0] ST_USR_ESC     = 4'd10;
    localparam logic [3:0] ST_BAD_NONCE   = 4'd11;

    // message section being parsed
    typedef enum logic [2:0] {
        SEC_FLAG  = 3'd0,
        SEC_AUTHZ = 3'd1,
        SEC_USER  = 3'd2,
        SEC_NONCE = 3'd3,
        SEC_EXT   = 3'd4
    } t_section;

    // character class of one byte, decided by the front end
    typedef struct packed {
        logic is_zero;
        logic is_comma;
        logic is_eq;
        logic is_two;
        logic is_three;
        logic is_cap_c;
        logic is_cap_d;
        logic is_p;
        logic is_y;
        logic is_n;
        logic is_m;
        logic is_r;
        logic is_a;
    } t_cls;

    // one queued item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        t_cls       cls;
    } t_item;

    // one result item
    typedef struct packed {
        logic [7:0] raw_byte;
        logic       in_header;
        logic       in_bare;
        logic       name_valid;
        logic       name_kind;
        logic [7:0] name_char;
        logic       nonce_valid;
        logic       done_res;
        logic [3:0] status;
    } t_result;

endpackage

FILE: rtl/core/scp_front.sv
// ============================================================================
// scp_front
// accepts message bytes and tags each with its character class
// ============================================================================
module scp_front
    import scp_pkg::*;
(
    input  logic       i_tvalid,
    input  logic [7:0] i_tdata,
    input  logic       i_tlast,
    input  logic       i_q_full,
    output logic       o_tready,
    output logic       o_push,
    output t_item      o_item
);

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;

    always_comb begin
        o_item              = '0;
        o_item.data_byte    = i_tdata;
        o_item.last         = i_tlast;
        o_item.cls.is_zero  = (i_tdata == CH_NUL);
        o_item.cls.is_comma = (i_tdata == CH_COMMA);
        o_item.cls.is_eq    = (i_tdata == CH_EQ);
        o_item.cls.is_two   = (i_tdata == CH_TWO);
        o_item.cls.is_three = (i_tdata == CH_THREE);
        o_item.cls.is_cap_c = (i_tdata == CH_CAP_C);
        o_item.cls.is_cap_d = (i_tdata == CH_CAP_D);
        o_item.cls.is_p     = (i_tdata == CH_P);
        o_item.cls.is_y     = (i_tdata == CH_Y);
        o_item.cls.is_n     = (i_tdata == CH_N);
        o_item.cls.is_m     = (i_tdata == CH_M);
        o_item.cls.is_r     = (i_tdata == CH_R);
        o_item.cls.is_a     = (i_tdata == CH_A);
    end

endmodule

FILE: rtl/core/scp_fifo.sv
// ============================================================================
// scp_fifo
// short queue of classified items between front end and parser
// ============================================================================
module scp_fifo
    import scp_pkg::*;
#(
    parameter int DEPTH = SCP_FIFO_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

FILE: rtl/core/scp_back.sv
// ============================================================================
// scp_back
// parser state machine and output register, one queued item per cycle while the output is not stalled
// ============================================================================
module scp_back
    import scp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_item   i_q_head,
    output logic    o_q_pop,
    output logic    o_tvalid,
    input  logic    i_tready,
    output t_result o_res
);

    t_section   r_section, n_section, w_sec_adv;
    logic [1:0] r_fp, n_fp;
    logic [1:0] r_esc, n_esc;
    logic       r_e3, n_e3;
    logic [1:0] r_comma, n_comma;
    logic [7:0] r_flags, n_flags;
    logic       r_ended, n_ended;
    logic       r_out_valid, n_out_valid;
    t_result    r_res, w_res;
    logic       w_pop;
    logic       w_dec_en;
    logic [7:0] w_dec_bit;
    t_cls       w_cls;

    // close a field on comma, zero byte or last byte
    function automatic logic [7:0] f_end_field(t_section sec, logic [1:0] fp,
                                               logic [1:0] esc, logic [7:0] fl);
        logic [7:0] res;
        res = fl;
        case (sec)
            SEC_FLAG: begin
                if (fp == 2'd0) res[F_BAD_GS2] = 1'b1;
            end
            SEC_AUTHZ: begin
                if (fp == 2'd1) res[F_BAD_AZ] = 1'b1;
                if (fp == 2'd2 && esc != ESC_NONE && !fl[F_BAD_AZ] && !fl[F_AZ_ESC] &&
                    fp != 2'd1) begin
                    res[F_AZ_ESC] = 1'b1;
                end
            end
            SEC_USER: begin
                if (fp != 2'd2) begin
                    res[F_BAD_USR] = 1'b1;
                end else if (esc != ESC_NONE && !fl[F_MEXT] && !fl[F_BAD_USR] &&
                             !fl[F_USR_ESC]) begin
                    res[F_USR_ESC] = 1'b1;
                end
            end
            SEC_NONCE: begin
                if (fp != 2'd2) res[F_BAD_NONCE] = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // comma structure first, then the lowest error flag
    function automatic logic [3:0] f_status(logic [1:0] cc, logic [7:0] fl);
        logic [3:0] st;
        st = ST_OK;
        for (int i = 7; i >= 0; i--) begin
            if (fl[i]) st = ST_CBIND_P + 4'(i);
        end
        case (cc)
            2'd0:    st = ST_NO_COMMA1;
            2'd1:    st = ST_NO_COMMA2;
            2'd2:    st = ST_NO_NONCE;
            default: ;
        endcase
        return st;
    endfunction

    assign w_pop    = i_q_valid && (!r_out_valid || i_tready);
    assign o_q_pop  = w_pop;
    assign o_tvalid = r_out_valid;
    assign o_res    = r_res;
    assign w_cls    = i_q_head.cls;

    // next section
    always_comb begin
        w_sec_adv = r_section;
        if (w_pop && !r_ended && !w_cls.is_zero && w_cls.is_comma) begin
            case (r_section)
                SEC_FLAG:  w_sec_adv = SEC_AUTHZ;
                SEC_AUTHZ: w_sec_adv = SEC_USER;
                SEC_USER:  w_sec_adv = SEC_NONCE;
                default:   w_sec_adv = SEC_EXT;
            endcase
        end
        n_section = (w_pop && i_q_head.last) ? SEC_FLAG : w_sec_adv;
    end

    // field checks, name decoding and result
    always_comb begin
        n_fp      = r_fp;
        n_esc     = r_esc;
        n_e3      = r_e3;
        n_comma   = r_comma;
        n_flags   = r_flags;
        n_ended   = r_ended;
        w_dec_en  = 1'b0;
        w_dec_bit = '0;
        w_res     = '0;
        w_res.raw_byte = i_q_head.data_byte;
        if (w_pop) begin
            if (!r_ended) begin
                if (w_cls.is_zero) begin
                    n_flags = f_end_field(r_section, r_fp, r_esc, r_flags);
                    n_ended = 1'b1;
                end else begin
                    w_res.in_header = (r_section == SEC_FLAG) || (r_section == SEC_AUTHZ);
                    w_res.in_bare   = !w_res.in_header;
                    if (w_cls.is_comma) begin
                        n_flags = f_end_field(r_section, r_fp, r_esc, r_flags);
                        if (r_comma != 2'd3) n_comma = r_comma + 1'b1;
                        n_fp  = '0;
                        n_esc = ESC_NONE;
                        n_e3  = 1'b0;
                    end else begin
                        case (r_section)
                            SEC_FLAG: begin
                                if (r_fp == 2'd0) begin
                                    if (w_cls.is_p) begin
                                        n_flags[F_CBIND_P] = 1'b1;
                                    end else if (!w_cls.is_y && !w_cls.is_n) begin
                                        n_flags[F_BAD_GS2] = 1'b1;
                                    end
                                end
                            end
                            SEC_AUTHZ: begin
                                if (r_fp == 2'd0) begin
                                    if (!w_cls.is_a) n_flags[F_BAD_AZ] = 1'b1;
                                end else if (r_fp == 2'd1) begin
                                    if (!w_cls.is_eq) n_flags[F_BAD_AZ] = 1'b1;
                                end else begin
                                    w_dec_en  = !r_flags[F_BAD_AZ] && !r_flags[F_AZ_ESC];
                                    w_dec_bit[F_AZ_ESC] = 1'b1;
                                end
                            end
                            SEC_USER: begin
                                if (r_fp == 2'd0) begin
                                    if (w_cls.is_m) begin
                                        n_flags[F_MEXT] = 1'b1;
                                    end else if (!w_cls.is_n) begin
                                        n_flags[F_BAD_USR] = 1'b1;
                                    end
                                end else if (r_fp == 2'd1) begin
                                    if (!w_cls.is_eq) n_flags[F_BAD_USR] = 1'b1;
                                end else begin
                                    w_dec_en  = !r_flags[F_MEXT] && !r_flags[F_BAD_USR] &&
                                                !r_flags[F_USR_ESC];
                                    w_dec_bit[F_USR_ESC] = 1'b1;
                                end
                            end
                            SEC_NONCE: begin
                                if (r_fp == 2'd0) begin
                                    if (!w_cls.is_r) n_flags[F_BAD_NONCE] = 1'b1;
                                end else if (r_fp == 2'd1) begin
                                    if (!w_cls.is_eq) n_flags[F_BAD_NONCE] = 1'b1;
                                end else begin
                                    w_res.nonce_valid = !r_flags[F_BAD_NONCE];
                                end
                            end
                            default: ;
                        endcase
                        // escape decoding shared by authzid and username
                        if (w_dec_en) begin
                            case (r_esc)
                                ESC_NONE: begin
                                    if (w_cls.is_eq) begin
                                        n_esc = ESC_EQ;
                                    end else begin
                                        w_res.name_valid = 1'b1;
                                        w_res.name_char  = i_q_head.data_byte;
                                    end
                                end
                                ESC_EQ: begin
                                    if (w_cls.is_two || w_cls.is_three) begin
                                        n_e3  = w_cls.is_three;
                                        n_esc = ESC_DIGIT;
                                    end else begin
                                        n_flags = n_flags | w_dec_bit;
                                        n_esc   = ESC_NONE;
                                    end
                                end
                                default: begin
                                    n_esc = ESC_NONE;
                                    if (!r_e3 && w_cls.is_cap_c) begin
                                        w_res.name_valid = 1'b1;
                                        w_res.name_char  = CH_COMMA;
                                    end else if (r_e3 && w_cls.is_cap_d) begin
                                        w_res.name_valid = 1'b1;
                                        w_res.name_char  = CH_EQ;
                                    end else begin
                                        n_flags = n_flags | w_dec_bit;
                                    end
                                end
                            endcase
                            w_res.name_kind = w_res.name_valid && (r_section == SEC_USER);
                        end
                        if (r_fp != 2'd2) n_fp = r_fp + 1'b1;
                    end
                    if (i_q_head.last) begin
                        n_flags = f_end_field(w_sec_adv, n_fp, n_esc, n_flags);
                    end
                end
            end
            if (i_q_head.last) begin
                w_res.done_res = 1'b1;
                w_res.status   = f_status(n_comma, n_flags);
                n_fp    = '0;
                n_esc   = ESC_NONE;
                n_e3    = 1'b0;
                n_comma = '0;
                n_flags = '0;
                n_ended = 1'b0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_pop) begin
            n_out_valid = 1'b1;
        end else if (i_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section   <= SEC_FLAG;
            r_fp        <= '0;
            r_esc       <= ESC_NONE;
            r_e3        <= 1'b0;
            r_comma     <= '0;
            r_flags     <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_section   <= n_section;
            r_fp        <= n_fp;
            r_esc       <= n_esc;
            r_e3        <= n_e3;
            r_comma     <= n_comma;
            r_flags     <= n_flags;
            r_ended     <= n_ended;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_res <= w_res;
        end
    end

    // a message end leaves the parser at its start state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && i_q_head.last |=> r_section == SEC_FLAG && r_comma == 2'd0 &&
                                   r_flags == 8'd0 && !r_ended)
        else $error("parser state not cleared after last item");

    // status only on the closing item
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.done_res |-> r_res.status == ST_OK)
        else $error("status set on an item that is not last");

    // header and bare tags exclude each other, as do name and nonce tags
    a_tags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.name_valid && r_res.nonce_valid) &&
                        !(r_res.in_header && r_res.in_bare))
        else $error("conflicting tags on one item");

endmodule

FILE: rtl/core/scram_client_first_parser.sv
// ============================================================================
// scram_client_first_parser
// streaming parser of a client-first message, tags and decodes every byte
// ============================================================================
//
//  channel   direction  tdata                        tuser            tlast
//  s_axis    in         data_byte                    -                last byte of message
//  m_axis    out        raw_byte, name_char, status  byte tags        done_res
//
//  one item per cycle sustained while the output is not stalled; an accepted
//  item passes the queue write, then the parser and output register, before it leaves
//  throughput is set by the single parser step, one queued item per cycle unless stalled
//  synchronous active-low reset empties the queue and restarts the parse
//  a stalled output holds the result while the queue keeps taking items
//  until it fills; s_axis_tready depends only on the queue fill
//
module scram_client_first_parser
    import scp_pkg::*;
#(
    parameter int FIFO_DEPTH = SCP_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] raw_byte, [15:8] name_char,
                                        // [19:16] status, [23:20] zero
    output logic [7:0]  m_axis_tuser,   // [0] in_header, [1] in_bare, [2] name_valid,
                                        // [3] name_kind, [4] nonce_valid, [7:5] zero
    output logic        m_axis_tlast    // done_res
);

    logic    w_push;
    t_item   w_push_item;
    logic    w_q_full;
    logic    w_q_valid;
    logic    w_q_pop;
    t_item   w_q_head;
    t_result w_res;

    // front end: byte intake and character classes
    scp_front u_front (
        .i_tvalid (s_axis_tvalid),
        .i_tdata  (s_axis_tdata),
        .i_tlast  (s_axis_tlast),
        .i_q_full (w_q_full),
        .o_tready (s_axis_tready),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    // decoupling queue
    scp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_q_full),
        .i_pop       (w_q_pop),
        .o_valid     (w_q_valid),
        .o_head      (w_q_head)
    );

    // back end: section tracking, checks, unescaping, output register
    scp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_head  (w_q_head),
        .o_q_pop   (w_q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_res     (w_res)
    );

    // pack result fields, lowest field first
    assign m_axis_tdata = {4'd0, w_res.status, w_res.name_char, w_res.raw_byte};
    assign m_axis_tuser = {3'd0, w_res.nonce_valid, w_res.name_kind, w_res.name_valid,
                           w_res.in_bare, w_res.in_header};
    assign m_axis_tlast = w_res.done_res;

endmodule

FILE: tb/sv/scram_client_first_parser_chk.sv
`timescale 1ns / 100ps
// ============================================================================
// scram_client_first_parser_chk
// watches both streams of the parser, predicts every result and compares it
// ============================================================================
module scram_client_first_parser_chk
    import scp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic [7:0]  i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    t_section   sect;
    logic [1:0] fpos;
    logic [1:0] esc_phase;
    logic       esc_three;
    logic [1:0] commas;
    logic [7:0] errs;
    logic       text_done;

    t_result    expected_q[$];
    t_result    want_r;
    int         result_idx;

    function automatic void clear_parse();
        sect      = SEC_FLAG;
        fpos      = 2'd0;
        esc_phase = ESC_NONE;
        esc_three = 1'b0;
        commas    = 2'd0;
        errs      = 8'h00;
        text_done = 1'b0;
    endfunction

    // unescape one name byte, 1 when a character comes out
    function automatic logic decode_name_byte(input logic [7:0] c, input int err_bit,
                                              output logic [7:0] ch);
        ch = 8'h00;
        case (esc_phase)
            ESC_NONE: begin
                if (c == CH_EQ) begin
                    esc_phase = ESC_EQ;
                    return 1'b0;
                end
                ch = c;
                return 1'b1;
            end
            ESC_EQ: begin
                if (c == CH_TWO || c == CH_THREE) begin
                    esc_three = (c == CH_THREE);
                    esc_phase = ESC_DIGIT;
                end else begin
                    errs[err_bit] = 1'b1;
                    esc_phase     = ESC_NONE;
                end
                return 1'b0;
            end
            default: begin
                esc_phase = ESC_NONE;
                if (!esc_three && c == CH_CAP_C) begin
                    ch = CH_COMMA;
                    return 1'b1;
                end
                if (esc_three && c == CH_CAP_D) begin
                    ch = CH_EQ;
                    return 1'b1;
                end
                errs[err_bit] = 1'b1;
                return 1'b0;
            end
        endcase
    endfunction

    // checks that apply when a field is closed by a comma, a zero or the last byte
    function automatic void close_field();
        case (sect)
            SEC_FLAG: begin
                if (fpos == 2'd0) errs[F_BAD_GS2] = 1'b1;
            end
            SEC_AUTHZ: begin
                if (fpos == 2'd1) errs[F_BAD_AZ] = 1'b1;
                if (fpos == 2'd2 && esc_phase != ESC_NONE && !errs[F_BAD_AZ] && !errs[F_AZ_ESC])
                    errs[F_AZ_ESC] = 1'b1;
            end
            SEC_USER: begin
                if (fpos < 2'd2) errs[F_BAD_USR] = 1'b1;
                if (fpos == 2'd2 && esc_phase != ESC_NONE &&
                    !errs[F_MEXT] && !errs[F_BAD_USR] && !errs[F_USR_ESC])
                    errs[F_USR_ESC] = 1'b1;
            end
            SEC_NONCE: begin
                if (fpos < 2'd2) errs[F_BAD_NONCE] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void field_byte(input logic [7:0] c, inout t_result r);
        logic [7:0] ch;
        case (sect)
            SEC_FLAG: begin
                if (fpos == 2'd0) begin
                    if (c == CH_P) errs[F_CBIND_P] = 1'b1;
                    else if (c != CH_Y && c != CH_N) errs[F_BAD_GS2] = 1'b1;
                end
            end
            SEC_AUTHZ: begin
                if (fpos == 2'd0) begin
                    if (c != CH_A) errs[F_BAD_AZ] = 1'b1;
                end else if (fpos == 2'd1) begin
                    if (c != CH_EQ) errs[F_BAD_AZ] = 1'b1;
                end else if (!errs[F_BAD_AZ] && !errs[F_AZ_ESC]) begin
                    if (decode_name_byte(c, F_AZ_ESC, ch)) begin
                        r.name_valid = 1'b1;
                        r.name_kind  = 1'b0;
                        r.name_char  = ch;
                    end
                end
            end
            SEC_USER: begin
                if (fpos == 2'd0) begin
                    if (c == CH_M) errs[F_MEXT] = 1'b1;
                    else if (c != CH_N) errs[F_BAD_USR] = 1'b1;
                end else if (fpos == 2'd1) begin
                    if (c != CH_EQ) errs[F_BAD_USR] = 1'b1;
                end else if (!errs[F_MEXT] && !errs[F_BAD_USR] && !errs[F_USR_ESC]) begin
                    if (decode_name_byte(c, F_USR_ESC, ch)) begin
                        r.name_valid = 1'b1;
                        r.name_kind  = 1'b1;
                        r.name_char  = ch;
                    end
                end
            end
            SEC_NONCE: begin
                if (fpos == 2'd0) begin
                    if (c != CH_R) errs[F_BAD_NONCE] = 1'b1;
                end else if (fpos == 2'd1) begin
                    if (c != CH_EQ) errs[F_BAD_NONCE] = 1'b1;
                end else if (!errs[F_BAD_NONCE]) begin
                    r.nonce_valid = 1'b1;
                end
            end
            default: ;
        endcase
        if (fpos < 2'd2) fpos = fpos + 2'd1;
    endfunction

    // comma structure first, then the lowest error flag
    function automatic logic [3:0] message_status();
        if (commas == 2'd0) return ST_NO_COMMA1;
        if (commas == 2'd1) return ST_NO_COMMA2;
        if (commas == 2'd2) return ST_NO_NONCE;
        for (int k = 0; k < 8; k++)
            if (errs[k]) return ST_CBIND_P + 4'(k);
        return ST_OK;
    endfunction

    function automatic t_result tag_byte(input logic [7:0] c, input logic last);
        t_result r;
        r          = '0;
        r.raw_byte = c;
        if (!text_done) begin
            if (c == CH_NUL) begin
                close_field();
                text_done = 1'b1;
            end else begin
                if (sect == SEC_FLAG || sect == SEC_AUTHZ) r.in_header = 1'b1;
                else r.in_bare = 1'b1;
                if (c == CH_COMMA) begin
                    close_field();
                    if (commas != 2'd3) commas = commas + 2'd1;
                    if (sect != SEC_EXT) sect = t_section'(sect + 3'd1);
                    fpos      = 2'd0;
                    esc_phase = ESC_NONE;
                    esc_three = 1'b0;
                end else begin
                    field_byte(c, r);
                end
                if (last) close_field();
            end
        end
        if (last) begin
            r.done_res = 1'b1;
            r.status   = message_status();
            clear_parse();
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] parser check: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      result_idx, name, got, want));
    endtask

    initial clear_parse();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            clear_parse();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(tag_byte(i_s_tdata, i_s_tlast));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing expected, data %0h",
                                              result_idx, i_m_tdata));
                end else begin
                    want_r = expected_q.pop_front();
                    check_field("raw_byte", i_m_tdata[7:0], want_r.raw_byte);
                    check_field("in_header", 8'(i_m_tuser[0]), 8'(want_r.in_header));
                    check_field("in_bare", 8'(i_m_tuser[1]), 8'(want_r.in_bare));
                    check_field("name_valid", 8'(i_m_tuser[2]), 8'(want_r.name_valid));
                    check_field("name_kind", 8'(i_m_tuser[3]), 8'(want_r.name_kind));
                    check_field("name_char", i_m_tdata[15:8], want_r.name_char);
                    check_field("nonce_valid", 8'(i_m_tuser[4]), 8'(want_r.nonce_valid));
                    check_field("status", 8'(i_m_tdata[19:16]), 8'(want_r.status));
                    check_field("pad", 8'(i_m_tdata[23:20]), 8'h00);
                    check_field("user pad", 8'(i_m_tuser[7:5]), 8'h00);
                    check_field("done_res", 8'(i_m_tlast), 8'(want_r.done_res));
                end
                result_idx++;
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: tb/sv/scram_client_first_parser_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// scram_client_first_parser_tb
// drives client-first messages into the parser and gives the verdict
// ============================================================================
//
// a short directed set of messages comes first, then random messages: about
// half well formed with random names, escapes and nonces, the rest carrying
// one defect each (binding flag, prefixes, escapes, truncation, zero byte)
// or plain noise. the sender works in bursts, the receiver stalls on its own
// pattern; the checker beside the block predicts and compares every item
//
module scram_client_first_parser_tb;
    import scp_pkg::*;

    localparam int ITEM_TARGET  = 1650;
    localparam int IDLE_LIMIT   = 3000;   // cycles without any handshake
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 16;

    // receiver stall patterns
    localparam int RX_ALWAYS = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_LIGHT  = 2;
    localparam int RX_FIXED  = 3;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;

    int          fail_cnt;
    int          pending_cnt;
    int          idle_cycles;
    int          sent_items;
    int          burst_left;
    logic        hold_req = 1'b0;   // set by the sender, cleared by the receiver
    logic [7:0]  msg_q[$];          // bytes of the message being built

    scram_client_first_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),    // [7:0] data_byte
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),    // raw_byte, name_char, status
        .m_axis_tuser  (m_tuser),    // in_header, in_bare, name_valid, name_kind, nonce_valid
        .m_axis_tlast  (m_tlast)     // done_res
    );

    scram_client_first_parser_chk u_parser_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_cnt),
        .o_pending    (pending_cnt)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: any accepted item on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver: pattern changes every so often, long hold-off on request
    initial begin : rx_side
        int mode;
        int mode_left;
        int tick;
        mode      = RX_ALWAYS;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(RX_ALWAYS, RX_FIXED);
                    mode_left = $urandom_range(30, 150);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                    RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= (tick % 5 != 0) && (tick % 7 != 3);
                endcase
            end
        end
    end

    // one item, offered from a falling edge until accepted; ends on a falling edge
    task automatic put_byte(input logic [7:0] b, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_items++;
        @(negedge i_clk);
    endtask

    // sends the built message in bursts with gaps between them
    task automatic send_message();
        for (int k = 0; k < msg_q.size(); k++) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                s_tlast  <= 1'($urandom);
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
            put_byte(msg_q[k], k == msg_q.size() - 1);
        end
        msg_q.delete();
    endtask

    // sender stops offering until every expected item has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic push_str(input string s);
        for (int k = 0; k < s.len(); k++) msg_q.push_back(s[k]);
    endtask

    // any byte that is neither zero, comma nor equals
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CH_COMMA || c == CH_EQ);
        return c;
    endfunction

    // name text with well-formed escapes mixed in
    task automatic push_name(input int n);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       push_str("=2C");
                1:       push_str("=3D");
                default: msg_q.push_back(plain_char());
            endcase
        end
    endtask

    task automatic push_bad_escape();
        case ($urandom_range(0, 5))
            0: push_str("=x");
            1: push_str("=2D");
            2: push_str("=3C");
            3: push_str("=");
            4: push_str("=3");
            default: begin
                push_str("=2");
                msg_q.push_back(plain_char());
            end
        endcase
    endtask

    task automatic push_nonce(input int n);
        logic [7:0] c;
        repeat (n) begin
            do c = 8'($urandom_range(1, 255));
            while (c == CH_COMMA);
            msg_q.push_back(c);
        end
    endtask

    task automatic build_random_message();
        int    pick;
        int    defect;
        int    cut;
        string alphabet;
        alphabet = ",=nyparm23CD";
        pick     = $urandom_range(0, 99);
        if (pick >= 90) begin
            // noise, parser symbols mixed with any byte including zero
            repeat ($urandom_range(1, 24)) begin
                case ($urandom_range(0, 15))
                    0:       msg_q.push_back(CH_NUL);
                    1, 2, 3: msg_q.push_back(8'($urandom));
                    default: msg_q.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
                endcase
            end
        end else begin
            defect = (pick < 50) ? 0 : $urandom_range(1, 12);
            // binding flag, only its first byte counts
            case (defect)
                1: push_str("p=tls-unique");
                2: msg_q.push_back(plain_char());
                3: ;
                default: begin
                    msg_q.push_back($urandom_range(0, 1) ? CH_Y : CH_N);
                    if ($urandom_range(0, 7) == 0) push_name(2);
                end
            endcase
            msg_q.push_back(CH_COMMA);
            // optional authzid
            case (defect)
                4: begin
                    case ($urandom_range(0, 2))
                        0: push_str("a");
                        1: begin
                            push_str("x=");
                            push_name($urandom_range(0, 3));
                        end
                        default: begin
                            push_str("ab");
                            push_name($urandom_range(0, 3));
                        end
                    endcase
                end
                5: begin
                    push_str("a=");
                    push_name($urandom_range(0, 3));
                    push_bad_escape();
                    push_name($urandom_range(0, 3));
                end
                default: begin
                    if ($urandom_range(0, 2) == 0) begin
                        push_str("a=");
                        push_name($urandom_range(0, 6));
                    end
                end
            endcase
            msg_q.push_back(CH_COMMA);
            // username or mandatory extension
            case (defect)
                6: begin
                    push_str("m=");
                    push_name($urandom_range(0, 4));
                end
                7: begin
                    case ($urandom_range(0, 3))
                        0: push_str("n");
                        1: begin
                            push_str("x=");
                            push_name($urandom_range(0, 3));
                        end
                        2: begin
                            push_str("nn");
                            push_name($urandom_range(0, 3));
                        end
                        default: ;
                    endcase
                end
                8: begin
                    push_str("n=");
                    push_name($urandom_range(0, 3));
                    push_bad_escape();
                    push_name($urandom_range(0, 3));
                end
                default: begin
                    push_str("n=");
                    push_name($urandom_range(0, 8));
                end
            endcase
            msg_q.push_back(CH_COMMA);
            // client nonce
            if (defect == 9) begin
                case ($urandom_range(0, 3))
                    0: push_str("r");
                    1: begin
                        push_str("x=");
                        push_nonce($urandom_range(0, 4));
                    end
                    2: ;
                    default: push_str("rr");
                endcase
            end else begin
                push_str("r=");
                push_nonce($urandom_range(0, 16));
            end
            // trailing extensions are only tagged
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    msg_q.push_back(CH_COMMA);
                    msg_q.push_back(plain_char());
                    push_str("=");
                    push_name($urandom_range(0, 5));
                end
            end
            if (defect == 10 || defect == 12) begin
                cut = $urandom_range(1, msg_q.size());
                while (msg_q.size() > cut) void'(msg_q.pop_back());
            end else if (defect == 11) begin
                // zero byte ends the text, the rest is ignored until last
                msg_q[$urandom_range(0, msg_q.size() - 1)] = CH_NUL;
            end
        end
    endtask

    // stimulus and verdict
    initial begin : tx_side
        int msg_idx;
        msg_idx    = 0;
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single top byte, lone zero, both escapes in authzid and
        // username with a top nonce byte, flag with extra byte plus m-ext,
        // extension field and bytes after a zero
        msg_q.push_back(8'hFF);
        send_message();
        msg_q.push_back(CH_NUL);
        send_message();
        push_str("n,a==2C,n==3D,r=");
        msg_q.push_back(8'hFF);
        send_message();
        push_str("yx,,m,r=,");
        msg_q.push_back(CH_NUL);
        msg_q.push_back(8'h80);
        send_message();
        wait_drained();

        while (sent_items < ITEM_TARGET) begin
            msg_idx++;
            // long receiver hold-off while the sender keeps offering
            if (msg_idx == 15 || msg_idx == 50) hold_req = 1'b1;
            if (msg_idx % 23 == 0) wait_drained();
            build_random_message();
            send_message();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/scp_pkg.sv
rtl/core/scp_front.sv
rtl/core/scp_fifo.sv
rtl/core/scp_back.sv
rtl/core/scram_client_first_parser.sv
tb/sv/scram_client_first_parser_chk.sv
tb/sv/scram_client_first_parser_tb.sv
